### rtl/hto_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hto_pkg
// Shared types and constants for the holding track reorder block.
// ----------------------------------------------------------------------------
package hto_pkg;

    localparam int DEF_TRACKS   = 4;
    localparam int DEF_MAX_CARS = 32;
    localparam int MAX_RESULTS  = 32;

    localparam int CAR_W      = 6;
    localparam int TRK_W      = 3;
    localparam int TCNT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_COUNT   = 1'b1;

    localparam logic [TCNT_W-1:0] TRACK_COUNT_RST = 3'd3;
    localparam logic [CAR_W-1:0]  CAR_COUNT_RST   = 6'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_PLACE,
        ST_DRAIN,
        ST_RELOAD,
        ST_RESCAN
    } hto_state_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } hto_store_op_t;

endpackage
`default_nettype wire

### rtl/hto_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hto_store
// Holding track stacks: one synchronous memory with the cars, fill counters
// and a cached top per track. A pop reloads the new top from memory in the
// following cycle.
// ----------------------------------------------------------------------------
module hto_store import hto_pkg::*; #(
    parameter int TRACKS   = DEF_TRACKS,
    parameter int MAX_CARS = DEF_MAX_CARS,
    localparam int IDX_W   = (TRACKS > 1) ? $clog2(TRACKS) : 1,
    localparam int FW      = $clog2(MAX_CARS + 1)
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire hto_store_op_t  op_i,
    input  wire  [IDX_W-1:0]    track_i,
    input  wire  [CAR_W-1:0]    car_i,
    output logic [FW-1:0]       fill_o [TRACKS],
    output logic [CAR_W-1:0]    top_o  [TRACKS]
);

    localparam int DEPTH  = TRACKS * MAX_CARS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CAR_W-1:0]  mem [DEPTH];
    logic [FW-1:0]     fill_reg [TRACKS];
    logic [CAR_W-1:0]  top_reg  [TRACKS];
    logic [CAR_W-1:0]  rd_data_reg;
    logic              reload_reg;
    logic [IDX_W-1:0]  reload_trk_reg;

    logic [FW-1:0]     cur_fill;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;

    assign cur_fill  = fill_reg[track_i];
    assign base_addr = ADDR_W'(track_i) * ADDR_W'(MAX_CARS);
    assign wr_addr   = base_addr + ADDR_W'(cur_fill);
    // new top after a pop sits two below the old fill
    assign rd_addr   = base_addr + ADDR_W'(cur_fill - FW'(2));
    assign rd_en     = op_i.pop && (cur_fill >= FW'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TRACKS; i++) begin
                fill_reg[i] <= '0;
            end
            reload_reg <= 1'b0;
        end else begin
            reload_reg <= op_i.pop;
            if (op_i.clear) begin
                for (int i = 0; i < TRACKS; i++) begin
                    fill_reg[i] <= '0;
                end
            end else if (op_i.push) begin
                fill_reg[track_i] <= cur_fill + FW'(1);
            end else if (op_i.pop) begin
                fill_reg[track_i] <= cur_fill - FW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_i.push) begin
            mem[wr_addr] <= car_i;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (op_i.pop) begin
            reload_trk_reg <= track_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (op_i.push) begin
            top_reg[track_i] <= car_i;
        end else if (reload_reg && (fill_reg[reload_trk_reg] != '0)) begin
            top_reg[reload_trk_reg] <= rd_data_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < TRACKS; i++) begin
            fill_o[i] = fill_reg[i];
            top_o[i]  = top_reg[i];
        end
    end

endmodule
`default_nettype wire

### rtl/holding_track_reorder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// holding_track_reorder_top
// Railroad car rearrangement with LIFO holding tracks.
// ----------------------------------------------------------------------------
// One car is handled at a time; s_ready is high only while the block is idle,
// and a finished result may still wait at the output then. A car to be placed
// on a track, or refused for want of one, passes DECIDE, SEARCH and PLACE; a
// car in an already failed sequence gets its failure result in DECIDE; a car
// sent straight to the output goes DECIDE, DRAIN, and then RELOAD, RESCAN and
// DRAIN again for each held car drained after it. The work rests on the scan
// over the cached track tops, one track per cycle, and on the registered
// memory read that reloads a track's top after a pop. The track memory needs
// no clearing pass after reset; only entries below a track's fill are ever read.
// ----------------------------------------------------------------------------
module holding_track_reorder_top import hto_pkg::*; #(
    parameter int TRACKS   = DEF_TRACKS,
    parameter int MAX_CARS = DEF_MAX_CARS
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [CAR_W-1:0]      s_car,
    input  wire                   s_first_of_sequence,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [CAR_W-1:0]      m_moved_car,
    output logic [TRK_W-1:0]      m_from_track,
    output logic [TRK_W-1:0]      m_to_track,
    output logic                  m_failed,
    output logic                  m_last,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(TRACKS + 1);
    localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int FW    = $clog2(MAX_CARS + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    hto_state_t        state_reg, state_next;
    logic [TCNT_W-1:0] track_count_reg, track_count_next;
    logic [CAR_W-1:0]  car_count_reg, car_count_next;
    logic [CAR_W-1:0]  car_reg, car_next;
    logic [CAR_W-1:0]  nw_reg, nw_next;
    logic [CAR_W-1:0]  min_held_reg, min_held_next;
    logic [CNT_W-1:0]  min_track_reg, min_track_next;
    logic              min_valid_reg, min_valid_next;
    logic              seq_failed_reg, seq_failed_next;
    logic [RES_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [CAR_W-1:0]  best_top_reg, best_top_next;
    logic              have_empty_reg, have_empty_next;
    logic [IDX_W-1:0]  empty_reg, empty_next;
    logic              bad_reg, bad_next;
    logic [CAR_W-1:0]  pend_car_reg, pend_car_next;
    logic [TRK_W-1:0]  pend_from_reg, pend_from_next;

    logic              m_valid_reg;
    logic [CAR_W-1:0]  m_car_reg;
    logic [TRK_W-1:0]  m_from_reg;
    logic [TRK_W-1:0]  m_to_reg;
    logic              m_failed_reg;
    logic              m_last_reg;

    logic              out_load;
    logic [CAR_W-1:0]  out_car;
    logic [TRK_W-1:0]  out_from;
    logic [TRK_W-1:0]  out_to;
    logic              out_fail;
    logic              out_last;
    logic              slot_free;

    hto_store_op_t     st_op;
    logic [IDX_W-1:0]  st_track;
    logic [FW-1:0]     fill [TRACKS];
    logic [CAR_W-1:0]  top  [TRACKS];

    logic [CNT_W-1:0]  active;
    logic [IDX_W-1:0]  sidx;
    logic [CNT_W-1:0]  min_trk_m1;
    logic [IDX_W-1:0]  min_idx;
    logic              min_in_range;
    logic [FW-1:0]     fill_at_min;
    logic              drain_more;
    logic              drain_bad;
    logic [IDX_W-1:0]  place_idx;
    logic [CNT_W-1:0]  place_trk;

    hto_store #(
        .TRACKS   (TRACKS),
        .MAX_CARS (MAX_CARS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_i    (st_op),
        .track_i (st_track),
        .car_i   (car_reg),
        .fill_o  (fill),
        .top_o   (top)
    );

    // track_count above TRACKS acts as TRACKS
    assign active = (int'(track_count_reg) > TRACKS) ? CNT_W'(TRACKS)
                                                     : CNT_W'(track_count_reg);
    assign sidx   = scan_reg[IDX_W-1:0];

    assign min_trk_m1   = min_track_reg - CNT_W'(1);
    assign min_idx      = min_trk_m1[IDX_W-1:0];
    assign min_in_range = (min_track_reg != '0) && (int'(min_track_reg) <= TRACKS);
    assign fill_at_min  = min_in_range ? fill[min_idx] : '0;
    assign drain_more   = (n_reg < RES_W'(MAX_RESULTS)) && min_valid_reg &&
                          (min_held_reg == nw_reg);
    assign drain_bad    = !min_in_range || (fill_at_min == '0);

    assign place_idx = found_reg ? best_reg : empty_reg;
    assign place_trk = CNT_W'(place_idx) + CNT_W'(1);

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next       = state_reg;
        track_count_next = track_count_reg;
        car_count_next   = car_count_reg;
        car_next         = car_reg;
        nw_next          = nw_reg;
        min_held_next    = min_held_reg;
        min_track_next   = min_track_reg;
        min_valid_next   = min_valid_reg;
        seq_failed_next  = seq_failed_reg;
        n_next           = n_reg;
        scan_next        = scan_reg;
        found_next       = found_reg;
        best_next        = best_reg;
        best_top_next    = best_top_reg;
        have_empty_next  = have_empty_reg;
        empty_next       = empty_reg;
        bad_next         = bad_reg;
        pend_car_next    = pend_car_reg;
        pend_from_next   = pend_from_reg;
        st_op            = '0;
        st_track         = '0;
        out_load         = 1'b0;
        out_car          = '0;
        out_from         = '0;
        out_to           = '0;
        out_fail         = 1'b0;
        out_last         = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TRACK_COUNT: track_count_next = cfg_data[TCNT_W-1:0];
                CFG_CAR_COUNT:   car_count_next   = cfg_data[CAR_W-1:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    car_next = s_car;
                    if (s_first_of_sequence) begin
                        st_op.clear     = 1'b1;
                        nw_next         = CAR_W'(1);
                        seq_failed_next = 1'b0;
                        min_valid_next  = 1'b0;
                        min_held_next   = car_count_reg + CAR_W'(1);
                        min_track_next  = '0;
                    end
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                if (seq_failed_reg) begin
                    if (slot_free) begin
                        out_load   = 1'b1;
                        out_fail   = 1'b1;
                        out_last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (car_reg == nw_reg) begin
                    pend_car_next  = car_reg;
                    pend_from_next = '0;
                    nw_next        = nw_reg + CAR_W'(1);
                    n_next         = RES_W'(1);
                    state_next     = ST_DRAIN;
                end else begin
                    scan_next       = '0;
                    found_next      = 1'b0;
                    have_empty_next = 1'b0;
                    state_next      = ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                if (scan_reg == active) begin
                    state_next = ST_PLACE;
                end else begin
                    if (fill[sidx] == '0) begin
                        if (!have_empty_reg) begin
                            have_empty_next = 1'b1;
                            empty_next      = sidx;
                        end
                    end else if (fill[sidx] < FW'(MAX_CARS)) begin
                        // tightest top above the car; first track wins a tie
                        if ((top[sidx] > car_reg) &&
                            (!found_reg || (top[sidx] < best_top_reg))) begin
                            found_next    = 1'b1;
                            best_next     = sidx;
                            best_top_next = top[sidx];
                        end
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            ST_PLACE: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                    if (!found_reg && !have_empty_reg) begin
                        seq_failed_next = 1'b1;
                        out_fail        = 1'b1;
                    end else begin
                        st_op.push = 1'b1;
                        st_track   = place_idx;
                        out_car    = car_reg;
                        out_to     = TRK_W'(place_trk);
                        if (!min_valid_reg || (car_reg < min_held_reg)) begin
                            min_valid_next = 1'b1;
                            min_held_next  = car_reg;
                            min_track_next = place_trk;
                        end
                    end
                end
            end

            ST_DRAIN: begin
                // pending result goes out once we know whether another follows
                if (slot_free) begin
                    out_load = 1'b1;
                    out_car  = pend_car_reg;
                    out_from = pend_from_reg;
                    if (!drain_more) begin
                        out_last   = 1'b1;
                        state_next = ST_IDLE;
                    end else if (drain_bad) begin
                        out_last       = 1'b1;
                        min_valid_next = 1'b0;
                        min_held_next  = car_count_reg + CAR_W'(1);
                        min_track_next = '0;
                        scan_next      = '0;
                        bad_next       = 1'b1;
                        state_next     = ST_RESCAN;
                    end else begin
                        st_op.pop      = 1'b1;
                        st_track       = min_idx;
                        pend_car_next  = min_held_reg;
                        pend_from_next = TRK_W'(min_track_reg);
                        n_next         = n_reg + RES_W'(1);
                        nw_next        = nw_reg + CAR_W'(1);
                        state_next     = ST_RELOAD;
                    end
                end
            end

            ST_RELOAD: begin
                // store writes the reloaded top at this edge
                min_valid_next = 1'b0;
                min_held_next  = car_count_reg + CAR_W'(1);
                min_track_next = '0;
                scan_next      = '0;
                bad_next       = 1'b0;
                state_next     = ST_RESCAN;
            end

            ST_RESCAN: begin
                if (scan_reg == active) begin
                    state_next = bad_reg ? ST_IDLE : ST_DRAIN;
                end else begin
                    if ((fill[sidx] != '0) &&
                        (!min_valid_reg || (top[sidx] < min_held_reg))) begin
                        min_valid_next = 1'b1;
                        min_held_next  = top[sidx];
                        min_track_next = scan_reg + CNT_W'(1);
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            track_count_reg <= TRACK_COUNT_RST;
            car_count_reg   <= CAR_COUNT_RST;
            nw_reg          <= CAR_W'(1);
            min_held_reg    <= CAR_COUNT_RST + CAR_W'(1);
            min_track_reg   <= '0;
            min_valid_reg   <= 1'b0;
            seq_failed_reg  <= 1'b0;
            n_reg           <= '0;
            bad_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            track_count_reg <= track_count_next;
            car_count_reg   <= car_count_next;
            nw_reg          <= nw_next;
            min_held_reg    <= min_held_next;
            min_track_reg   <= min_track_next;
            min_valid_reg   <= min_valid_next;
            seq_failed_reg  <= seq_failed_next;
            n_reg           <= n_next;
            bad_reg         <= bad_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        car_reg        <= car_next;
        scan_reg       <= scan_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        best_top_reg   <= best_top_next;
        have_empty_reg <= have_empty_next;
        empty_reg      <= empty_next;
        pend_car_reg   <= pend_car_next;
        pend_from_reg  <= pend_from_next;
        if (out_load) begin
            m_car_reg    <= out_car;
            m_from_reg   <= out_from;
            m_to_reg     <= out_to;
            m_failed_reg <= out_fail;
            m_last_reg   <= out_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_moved_car  = m_car_reg;
    assign m_from_track = m_from_reg;
    assign m_to_track   = m_to_reg;
    assign m_failed     = m_failed_reg;
    assign m_last       = m_last_reg;

    // min tracking: a held minimum always names its track
    a_min_track: assert property (@(posedge aclk) disable iff (!aresetn)
        min_valid_reg == (min_track_reg != '0))
        else $error("min_valid and min_track disagree");

    a_result_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= RES_W'(MAX_RESULTS))
        else $error("result count beyond limit");

    a_fail_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_failed_reg |-> (m_car_reg == '0) && (m_to_reg == '0))
        else $error("failure result carries a car");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted item left no work");

    a_load_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> slot_free)
        else $error("result overwrote a waiting result");

endmodule
`default_nettype wire
